[hdl/csp_pkg.sv]
// Package for the cone support point block: widths, pipeline lengths, register
// indexes, reset values, the axial case code and the sideband struct.
// Depends on nothing; every other file of the block imports it.
package csp_pkg;

  // Field and register widths.
  localparam int DIR_W   = 16;             // direction components, signed Q2.14
  localparam int MAG_W   = 16;             // magnitude of a direction component
  localparam int POINT_W = 32;             // result components, signed Q16.16
  localparam int CFG_W   = 31;             // widest configuration register
  localparam int TOL_W   = 16;             // tolerance register
  localparam int IDX_W   = 2;              // configuration register index

  // Square root unit: 32-bit radicand scaled by 2^32, one result bit a stage.
  localparam int SQIN_W   = 32;
  localparam int SQ_W     = 2 * SQIN_W;
  localparam int SQ_STEPS = SQIN_W;
  localparam int ROOT_W   = SQ_STEPS;

  // Divider: Q1.30 normalized magnitude, one quotient bit a stage, two lanes.
  localparam int NORM_W    = 31;
  localparam int DIV_STEPS = NORM_W;
  localparam int LANES     = 2;
  localparam int DVD_SHIFT = 46;
  localparam int DVD_W     = MAG_W + DVD_SHIFT;

  // Sideband delay line spans the square root unit and the divider.
  localparam int PIPE_LEN = SQ_STEPS + DIV_STEPS;

  // Rim product and dot product widths.
  localparam int RND_SH = 30;
  localparam int PROD_W = 2 * NORM_W;
  localparam int DOT_W  = MAG_W + NORM_W;
  localparam int LHS_W  = DIR_W + POINT_W;

  localparam logic [PROD_W-1:0] PROD_RND = PROD_W'(1) << (RND_SH - 1);
  localparam logic [NORM_W-1:0] ONE_Q30  = NORM_W'(1) << RND_SH;

  // Directions at or beyond this magnitude of x are treated as lying on the axis.
  localparam logic signed [DIR_W-1:0] AXIAL_LIM = DIR_W'((9999 * 16384) / 10000 + 1);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_RADIUS      = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TOLERANCE   = IDX_W'(2);

  // Register reset values.
  localparam logic [CFG_W-1:0] RADIUS_RST      = CFG_W'(65536);
  localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = CFG_W'(65536);
  localparam logic [TOL_W-1:0] TOLERANCE_RST   = TOL_W'(0);

  typedef enum logic [1:0] {
    AXIS_NONE,
    AXIS_NEG,
    AXIS_POS
  } axis_e;

  // Per-item data that rides alongside the square root and divide pipelines.
  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic [MAG_W-1:0]        ymag;
    logic [MAG_W-1:0]        zmag;
    logic                    yneg;
    logic                    zneg;
    logic                    shrink;
    logic                    mzero;
    axis_e                   axis;
  } side_t;

endpackage

[hdl/csp_isqrt.sv]
// Pipelined integer square root: floor(sqrt(rad * 2^32)), one result bit per stage.
// Depends on csp_pkg for widths and the stage count.
module csp_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [csp_pkg::SQIN_W-1:0]   rad_i,
  output logic [csp_pkg::ROOT_W-1:0]   root_o
);
  import csp_pkg::*;

  logic [SQ_W-1:0] res_q [SQ_STEPS];
  logic [SQ_W-1:0] v_q   [SQ_STEPS-1];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (SQ_W - 2 - 2 * i);

    logic [SQ_W-1:0] v_in;
    logic [SQ_W-1:0] res_in;
    logic [SQ_W-1:0] trial;
    logic            take;

    if (i == 0) begin : g_first
      assign v_in   = {rad_i, {SQIN_W{1'b0}}};
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign res_in = res_q[i-1];
    end

    assign trial = res_in + Bit;
    assign take  = (v_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[i] <= take ? ((res_in >> 1) + Bit) : (res_in >> 1);
      end
    end

    // The remainder is not needed after the last stage.
    if (i < SQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[i] <= take ? (v_in - trial) : v_in;
        end
      end
    end
  end

  assign root_o = res_q[SQ_STEPS-1][ROOT_W-1:0];

endmodule

[hdl/csp_div.sv]
// Pipelined restoring divider, two lanes sharing one divisor: rounded
// (mag * 2^46) / root as a Q1.30 magnitude, one quotient bit per stage.
// Depends on csp_pkg for widths and the stage count.
module csp_div (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [csp_pkg::ROOT_W-1:0]              root_i,
  input  logic [csp_pkg::LANES-1:0][csp_pkg::MAG_W-1:0]  mag_i,
  output logic [csp_pkg::LANES-1:0][csp_pkg::NORM_W-1:0] quo_o
);
  import csp_pkg::*;

  // The divisor travels with the partial remainders.
  logic [ROOT_W-1:0] root_q [DIV_STEPS-1];

  for (genvar j = 0; j < DIV_STEPS - 1; j++) begin : g_root
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          root_q[j] <= root_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          root_q[j] <= root_q[j-1];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DVD_W-1:0]  dvd;
    logic [ROOT_W-1:0] rem_q [DIV_STEPS-1];
    logic [NORM_W-1:0] low_q [DIV_STEPS-1];
    logic [NORM_W-1:0] quo_q [DIV_STEPS];

    // Half the divisor is added up front so the quotient rounds half up.
    assign dvd = {mag_i[l], {DVD_SHIFT{1'b0}}} + DVD_W'(root_i[ROOT_W-1:1]);

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [ROOT_W-1:0] rem_in;
      logic [ROOT_W-1:0] rt;
      logic [NORM_W-1:0] low_in;
      logic [NORM_W-1:0] quo_in;
      logic [ROOT_W:0]   trial;
      logic              take;

      if (j == 0) begin : g_first
        assign rem_in = ROOT_W'(dvd[DVD_W-1:NORM_W]);
        assign low_in = dvd[NORM_W-1:0];
        assign quo_in = '0;
        assign rt     = root_i;
      end else begin : g_next
        assign rem_in = rem_q[j-1];
        assign low_in = low_q[j-1];
        assign quo_in = quo_q[j-1];
        assign rt     = root_q[j-1];
      end

      assign trial = {rem_in, low_in[NORM_W-1]};
      assign take  = (trial >= {1'b0, rt});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[j] <= {quo_in[NORM_W-2:0], take};
        end
      end

      if (j < DIV_STEPS - 1) begin : g_rem
        logic [ROOT_W:0] diff;

        assign diff = trial - {1'b0, rt};

        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[j] <= take ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
            low_q[j] <= {low_in[NORM_W-2:0], 1'b0};
          end
        end
      end
    end

    assign quo_o[l] = quo_q[DIV_STEPS-1];
  end

endmodule

[hdl/cone_support_point.sv]
// Path: an item passes the input register, stages B and C, the square root unit, the divider,
// stages E to H and the output register before its result shows on the output.
// Throughput: one item per cycle unless stalled; square root and divide are fully pipelined.
// The input stall is the output stall gated by a held result, so a stall freezes every stage.
// Reset: radius and half height return to 1.0, tolerance to 0, all valid flags clear.
// No memories, so no clearing pass follows reset.
module cone_support_point (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [csp_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [csp_pkg::DIR_W-1:0]   dir_y_i,
  input  logic signed [csp_pkg::DIR_W-1:0]   dir_z_i,
  input  logic                               shrink_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [csp_pkg::POINT_W-1:0] point_x_o,
  output logic signed [csp_pkg::POINT_W-1:0] point_y_o,
  output logic signed [csp_pkg::POINT_W-1:0] point_z_o,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [csp_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [csp_pkg::CFG_W-1:0]          cfg_data_i
);
  import csp_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration. The shrunk radius and half height are kept registered so the
  // datapath only picks between two ready values. The user must send writes only while
  // the pipeline is empty; the block does not enforce it. These copies follow the written
  // registers in the next cycle, long before any item reaches the stages that read them.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] radius_q;
  logic [CFG_W-1:0] half_height_q;
  logic [TOL_W-1:0] tolerance_q;
  logic [CFG_W-1:0] rs_q;
  logic [CFG_W-1:0] hs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= RADIUS_RST;
      half_height_q <= HALF_HEIGHT_RST;
      tolerance_q   <= TOLERANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS:      radius_q      <= cfg_data_i;
        REG_HALF_HEIGHT: half_height_q <= cfg_data_i;
        REG_TOLERANCE:   tolerance_q   <= cfg_data_i[TOL_W-1:0];
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= RADIUS_RST;
      hs_q <= HALF_HEIGHT_RST;
    end else begin
      rs_q <= (radius_q > CFG_W'(tolerance_q)) ? (radius_q - CFG_W'(tolerance_q)) : '0;
      hs_q <= (half_height_q > CFG_W'(tolerance_q)) ?
              (half_height_q - CFG_W'(tolerance_q)) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Every stage advances together unless a finished result sits in
  // the output register and the consumer stalls. An empty output register lets
  // the pipeline keep moving, so bubbles never block new transfers.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage A: input register.
  logic                    a_vld_q;
  logic signed [DIR_W-1:0] a_x_q;
  logic signed [DIR_W-1:0] a_y_q;
  logic signed [DIR_W-1:0] a_z_q;
  logic                    a_shrink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q      <= dir_x_i;
      a_y_q      <= dir_y_i;
      a_z_q      <= dir_z_i;
      a_shrink_q <= shrink_i;
    end
  end

  // Stage B: squares of the yz part, magnitudes and signs, and the axial test.
  // The axial thresholds are the exact integer form of |x| > 0.9999.
  logic signed [2*DIR_W-1:0] y_sq;
  logic signed [2*DIR_W-1:0] z_sq;
  axis_e                     b_axis;
  logic                      b_vld_q;
  logic [NORM_W-1:0]         b_y2_q;
  logic [NORM_W-1:0]         b_z2_q;
  side_t                     b_side_q;

  assign y_sq = (2*DIR_W)'(a_y_q) * (2*DIR_W)'(a_y_q);
  assign z_sq = (2*DIR_W)'(a_z_q) * (2*DIR_W)'(a_z_q);

  always_comb begin
    priority if (a_x_q <= -AXIAL_LIM) begin
      b_axis = AXIS_NEG;
    end else if (a_x_q >= AXIAL_LIM) begin
      b_axis = AXIS_POS;
    end else begin
      b_axis = AXIS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_y2_q          <= y_sq[NORM_W-1:0];
      b_z2_q          <= z_sq[NORM_W-1:0];
      b_side_q.x      <= a_x_q;
      b_side_q.ymag   <= a_y_q[DIR_W-1] ? MAG_W'(-a_y_q) : MAG_W'(a_y_q);
      b_side_q.zmag   <= a_z_q[DIR_W-1] ? MAG_W'(-a_z_q) : MAG_W'(a_z_q);
      b_side_q.yneg   <= a_y_q[DIR_W-1];
      b_side_q.zneg   <= a_z_q[DIR_W-1];
      b_side_q.shrink <= a_shrink_q;
      b_side_q.mzero  <= 1'b0;
      b_side_q.axis   <= b_axis;
    end
  end

  // Stage C: squared length of the yz part, and whether it is zero.
  logic [SQIN_W-1:0] m_sum;
  side_t             c_side_d;
  logic              c_vld_q;
  logic [SQIN_W-1:0] c_m_q;
  side_t             c_side_q;

  assign m_sum = {1'b0, b_y2_q} + {1'b0, b_z2_q};

  always_comb begin
    c_side_d       = b_side_q;
    c_side_d.mzero = (m_sum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_m_q    <= m_sum;
      c_side_q <= c_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root and divide. The root of the yz length feeds two divider lanes
  // that normalize |y| and |z|. The sideband delay line keeps each item's
  // remaining fields in step: slot k lines up with square root stage k for the
  // first stretch and with divider stage k - SQ_STEPS after that.
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0]                 root;
  logic [LANES-1:0][MAG_W-1:0]       div_mag;
  logic [LANES-1:0][NORM_W-1:0]      quo;
  logic [PIPE_LEN-1:0]               vld_q;
  side_t                             side_q [PIPE_LEN];

  csp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (c_m_q),
    .root_o (root)
  );

  // Lane 0 normalizes y, lane 1 normalizes z.
  assign div_mag = {side_q[SQ_STEPS-1].zmag, side_q[SQ_STEPS-1].ymag};

  csp_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .root_i (root),
    .mag_i  (div_mag),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], c_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= c_side_q;
      for (int k = 1; k < PIPE_LEN; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage E: the normalized magnitudes are capped at 1.0.
  logic              e_vld_q;
  logic [NORM_W-1:0] e_ny_q;
  logic [NORM_W-1:0] e_nz_q;
  side_t             e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= vld_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ny_q   <= (quo[0] > ONE_Q30) ? ONE_Q30 : quo[0];
      e_nz_q   <= (quo[1] > ONE_Q30) ? ONE_Q30 : quo[1];
      e_side_q <= side_q[PIPE_LEN-1];
    end
  end

  // Stage F: radius times each normalized magnitude.
  logic [CFG_W-1:0]  r_eff;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_z;
  logic              f_vld_q;
  logic [PROD_W-1:0] f_prod_y_q;
  logic [PROD_W-1:0] f_prod_z_q;
  side_t             f_side_q;

  assign r_eff  = e_side_q.shrink ? rs_q : radius_q;
  assign prod_y = PROD_W'(r_eff) * PROD_W'(e_ny_q);
  assign prod_z = PROD_W'(r_eff) * PROD_W'(e_nz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_prod_y_q <= prod_y;
      f_prod_z_q <= prod_z;
      f_side_q   <= e_side_q;
    end
  end

  // Stage G: round the products back to Q16.16. A zero yz part has no
  // direction, so its rim offsets are forced to zero.
  logic [PROD_W-1:0] rnd_y;
  logic [PROD_W-1:0] rnd_z;
  logic              g_vld_q;
  logic [NORM_W-1:0] g_py_q;
  logic [NORM_W-1:0] g_pz_q;
  side_t             g_side_q;

  assign rnd_y = f_prod_y_q + PROD_RND;
  assign rnd_z = f_prod_z_q + PROD_RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_py_q   <= f_side_q.mzero ? '0 : rnd_y[RND_SH +: NORM_W];
      g_pz_q   <= f_side_q.mzero ? '0 : rnd_z[RND_SH +: NORM_W];
      g_side_q <= f_side_q;
    end
  end

  // Stage H: dot product terms. Since each rim offset has the sign of its
  // direction component, y*ry is just |y| times the rim magnitude. The apex
  // side is 2*x*h, with the doubling left to the compare. Signed rim offsets
  // and both signs of h are prepared here for the final select.
  logic [CFG_W-1:0]          h_eff;
  logic [POINT_W-1:0]        h_pos;
  logic [POINT_W-1:0]        ry_mag;
  logic [POINT_W-1:0]        rz_mag;
  logic                      h_vld_q;
  logic [DOT_W-1:0]          h_dy_q;
  logic [DOT_W-1:0]          h_dz_q;
  logic signed [LHS_W-1:0]   h_lhs_q;
  logic signed [POINT_W-1:0] h_hpos_q;
  logic signed [POINT_W-1:0] h_hneg_q;
  logic signed [POINT_W-1:0] h_ry_q;
  logic signed [POINT_W-1:0] h_rz_q;
  side_t                     h_side_q;

  assign h_eff  = g_side_q.shrink ? hs_q : half_height_q;
  assign h_pos  = {1'b0, h_eff};
  assign ry_mag = {1'b0, g_py_q};
  assign rz_mag = {1'b0, g_pz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (en) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_dy_q   <= DOT_W'(g_side_q.ymag) * DOT_W'(g_py_q);
      h_dz_q   <= DOT_W'(g_side_q.zmag) * DOT_W'(g_pz_q);
      h_lhs_q  <= LHS_W'($signed(g_side_q.x)) * LHS_W'($signed(h_pos));
      h_hpos_q <= $signed(h_pos);
      h_hneg_q <= $signed(POINT_W'(0) - h_pos);
      h_ry_q   <= $signed(g_side_q.yneg ? (POINT_W'(0) - ry_mag) : ry_mag);
      h_rz_q   <= $signed(g_side_q.zneg ? (POINT_W'(0) - rz_mag) : rz_mag);
      h_side_q <= g_side_q;
    end
  end

  // Output stage: apex against rim, with the apex winning ties. Axial
  // directions skip the comparison and take the base center or the apex.
  logic [LHS_W-1:0]          rhs;
  logic                      apex;
  logic signed [POINT_W-1:0] px;
  logic signed [POINT_W-1:0] py;
  logic signed [POINT_W-1:0] pz;
  logic signed [POINT_W-1:0] point_x_q;
  logic signed [POINT_W-1:0] point_y_q;
  logic signed [POINT_W-1:0] point_z_q;

  assign rhs  = {1'b0, h_dy_q} + {1'b0, h_dz_q};
  assign apex = ($signed({h_lhs_q, 1'b0}) >= $signed({1'b0, rhs}));

  always_comb begin
    unique case (h_side_q.axis)
      AXIS_NEG: begin
        px = h_hneg_q;
        py = '0;
        pz = '0;
      end
      AXIS_POS: begin
        px = h_hpos_q;
        py = '0;
        pz = '0;
      end
      AXIS_NONE: begin
        px = apex ? h_hpos_q : h_hneg_q;
        py = apex ? '0 : h_ry_q;
        pz = apex ? '0 : h_rz_q;
      end
      default: begin
        px = h_hpos_q;
        py = '0;
        pz = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      point_x_q <= px;
      point_y_q <= py;
      point_z_q <= pz;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = point_x_q;
  assign point_y_o   = point_y_q;
  assign point_z_o   = point_z_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The input side only stalls while a finished result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled without a held result");

  // Whenever the pipeline advances, the last stage's valid flag lands in the
  // output register, so no item is dropped or duplicated at the end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (out_valid_q == $past(h_vld_q)))
    else $error("output valid lost track of the last stage");

  // An axial direction always yields a point on the axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && h_vld_q && h_side_q.axis != AXIS_NONE) |=>
      (point_y_o == '0 && point_z_o == '0))
    else $error("axial direction produced an off-axis point");

endmodule
